// ----- design/euclidean_rhythm_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Euclidean rhythm generator assertion macros
// Shared property wrappers, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_RHYTHM_GENERATOR_DEFINES_SVH
`define EUCLIDEAN_RHYTHM_GENERATOR_DEFINES_SVH

// same-cycle implication
`define ERG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ERG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/erg_pkg.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm generator package
// Widths, request kinds and the structs shared between the blocks.
// ----------------------------------------------------------------------------
package erg_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam int CNT_W         = 5;                    // hit/step count width
    localparam int CNT_CW        = $clog2(CNT_W + 1);    // divider iteration counter
    localparam int PAT_W         = 16;                   // output pattern width
    localparam int LVL_W         = 4;                    // level index width
    localparam int LVL_N         = 1 << LVL_W;           // level slots / stack depth
    localparam int LEN_W         = 6;                    // emitted length counter
    localparam logic [LEN_W-1:0] LEN_CAP = {LEN_W{1'b1}};
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    // request kinds, set by the front end
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_RUN  = 2'd0;   // needs the full computation
    localparam t_kind KIND_ZERO = 2'd1;   // no hits: zero pattern
    localparam t_kind KIND_BAD  = 2'd2;   // rejected: zero pattern, invalid

    typedef struct packed {
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] steps;
        t_kind            kind;
    } t_job;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quo;
        logic [CNT_W-1:0] rmd;
    } t_div_rsp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

endpackage

// ----- design/erg_front.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm front end
// Accepts requests and tags each one as rejected, trivial or to be computed.
// ----------------------------------------------------------------------------
module erg_front import erg_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CNT_W-1:0] i_hit_count,
    input  logic [CNT_W-1:0] i_step_count,
    input  t_q_sts           i_q_sts,
    output logic             o_push,
    output t_job             o_job
);

    localparam logic [CNT_W:0] MAX_S = (CNT_W + 1)'(MAX_STEPS);

    logic bad;

    // accept whenever the queue has room
    assign o_ready = !i_q_sts.full;
    assign o_push  = i_valid && !i_q_sts.full;

    // classify the request
    assign bad = (i_step_count == '0) || (i_hit_count > i_step_count)
              || ({1'b0, i_step_count} > MAX_S);

    always_comb begin
        o_job.hits  = i_hit_count;
        o_job.steps = i_step_count;
        priority if (bad) begin
            o_job.kind = KIND_BAD;
        end else if (i_hit_count == '0) begin
            o_job.kind = KIND_ZERO;
        end else begin
            o_job.kind = KIND_RUN;
        end
    end

endmodule

// ----- design/erg_queue.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm request queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module erg_queue import erg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_q_sts o_sts
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head      = r_mem[r_rp];
    assign o_sts.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_sts.empty = (r_cnt == '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ----- design/erg_div.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm divider
// Restoring divider, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module erg_div import erg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output t_div_rsp         o_rsp
);

    logic [CNT_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_dsr;
    logic [CNT_CW-1:0] r_cnt;
    logic              r_done;

    logic [CNT_W:0] shifted;
    logic [CNT_W:0] diff;
    logic           ge;

    // one trial subtraction
    assign shifted = {r_acc, r_quo[CNT_W-1]};
    assign ge      = (shifted >= {1'b0, r_dsr});
    assign diff    = shifted - {1'b0, r_dsr};

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rmd  = r_acc;

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_CW'(CNT_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_CW'(1));
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_acc <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo <= {r_quo[CNT_W-2:0], ge};
        end
    end

endmodule

// ----- design/erg_back.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm back end
// Runs the division chain, expands the level tree bit by bit through a frame
// stack, left-aligns the pattern and holds the result for the output side.
// ----------------------------------------------------------------------------
module erg_back import erg_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_head,
    input  t_q_sts           i_q_sts,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PAT_W-1:0] o_pattern,
    output logic             o_invalid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_DWAIT = 3'd2;
    localparam logic [2:0] S_TOP   = 3'd3;
    localparam logic [2:0] S_EXP   = 3'd4;
    localparam logic [2:0] S_NORM  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // one expansion frame: level, repeats done, remainder branch done
    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic [CNT_W-1:0] idx;
        logic             rd;
    } t_frame;

    logic [2:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_dvd, n_dvd;
    logic [CNT_W-1:0]     r_r, n_r;
    logic [LVL_W-1:0]     r_lvl, n_lvl;
    logic                 r_inv, n_inv;
    t_frame               r_f, n_f;
    logic [LVL_W:0]       r_sp, n_sp;
    logic [MAX_STEPS-1:0] r_w, n_w;
    logic                 r_lost, n_lost;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_ovalid, n_ovalid;
    logic [PAT_W-1:0]     r_opat, n_opat;
    logic                 r_oinv, n_oinv;

    logic [CNT_W-1:0] r_cnt_a [LVL_N];
    logic [CNT_W-1:0] r_rem_a [LVL_N];
    t_frame           r_stk   [LVL_N];

    logic             cnt_we, rem_we, stk_we;
    logic [LVL_W-1:0] cnt_wa, rem_wa;
    logic [CNT_W-1:0] cnt_wd, rem_wd;
    t_frame           stk_wd;
    logic [LVL_W:0]   sp_m1;
    logic [CNT_W-1:0] cur_cnt, cur_rem;
    logic             emit_en, emit_bit;
    logic             div_start;
    t_div_rsp         div_rsp;

    erg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_r),
        .o_rsp      (div_rsp)
    );

    assign sp_m1   = r_sp - 1'b1;
    assign cur_cnt = r_cnt_a[r_f.lvl];
    assign cur_rem = r_rem_a[r_f.lvl];

    assign o_valid   = r_ovalid;
    assign o_pattern = r_opat;
    assign o_invalid = r_oinv;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_dvd     = r_dvd;
        n_r       = r_r;
        n_lvl     = r_lvl;
        n_inv     = r_inv;
        n_f       = r_f;
        n_sp      = r_sp;
        n_w       = r_w;
        n_lost    = r_lost;
        n_len     = r_len;
        n_ovalid  = r_ovalid;
        n_opat    = r_opat;
        n_oinv    = r_oinv;
        o_pop     = 1'b0;
        div_start = 1'b0;
        cnt_we    = 1'b0;
        cnt_wa    = r_lvl;
        cnt_wd    = div_rsp.quo;
        rem_we    = 1'b0;
        rem_wa    = r_lvl + 1'b1;
        rem_wd    = div_rsp.rmd;
        stk_we    = 1'b0;
        stk_wd    = r_f;
        emit_en   = 1'b0;
        emit_bit  = 1'b0;

        // result taken downstream
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_sts.empty) begin
                    o_pop = 1'b1;
                    n_inv = (i_head.kind == KIND_BAD);
                    if (i_head.kind == KIND_RUN) begin
                        n_dvd   = i_head.steps - i_head.hits;
                        n_r     = i_head.hits;
                        n_lvl   = '0;
                        rem_we  = 1'b1;
                        rem_wa  = '0;
                        rem_wd  = i_head.hits;
                        n_state = S_DIV;
                    end else begin
                        n_w     = '0;
                        n_lost  = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state   = S_DWAIT;
            end
            // store count and remainder of this level, step down the chain
            S_DWAIT: begin
                if (div_rsp.done) begin
                    cnt_we = 1'b1;
                    rem_we = 1'b1;
                    n_dvd  = r_r;
                    n_r    = div_rsp.rmd;
                    n_lvl  = r_lvl + 1'b1;
                    if (div_rsp.rmd <= CNT_W'(1)) begin
                        n_state = S_TOP;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_TOP: begin
                cnt_we    = 1'b1;
                cnt_wd    = r_dvd;
                n_f.lvl   = r_lvl;
                n_f.idx   = '0;
                n_f.rd    = 1'b0;
                n_sp      = '0;
                n_w       = '0;
                n_lost    = 1'b0;
                n_len     = '0;
                n_state   = S_EXP;
            end
            // one tree step per cycle: emit a leaf, descend, or return
            S_EXP: begin
                priority if (r_f.idx < cur_cnt) begin
                    if (r_f.lvl == '0) begin
                        emit_en   = 1'b1;
                        emit_bit  = 1'b0;
                        n_f.idx   = r_f.idx + 1'b1;
                    end else begin
                        stk_we     = 1'b1;
                        stk_wd.idx = r_f.idx + 1'b1;
                        n_sp       = r_sp + 1'b1;
                        n_f.lvl    = r_f.lvl - 1'b1;
                        n_f.idx    = '0;
                        n_f.rd     = 1'b0;
                    end
                end else if (!r_f.rd && (cur_rem != '0)) begin
                    if (r_f.lvl <= LVL_W'(1)) begin
                        emit_en  = 1'b1;
                        emit_bit = (r_f.lvl == '0);
                        n_f.rd   = 1'b1;
                    end else begin
                        stk_we    = 1'b1;
                        stk_wd.rd = 1'b1;
                        n_sp      = r_sp + 1'b1;
                        n_f.lvl   = r_f.lvl - LVL_W'(2);
                        n_f.idx   = '0;
                        n_f.rd    = 1'b0;
                    end
                end else if (r_sp == '0) begin
                    n_state = S_NORM;
                end else begin
                    n_f  = r_stk[sp_m1[LVL_W-1:0]];
                    n_sp = sp_m1;
                end
                // shift the emitted step in; a hit falling off the top is lost
                if (emit_en && (r_len != LEN_CAP)) begin
                    n_w    = {r_w[MAX_STEPS-2:0], emit_bit};
                    n_lost = r_lost | r_w[MAX_STEPS-1];
                    n_len  = r_len + 1'b1;
                end
            end
            // left-align, one position per cycle
            S_NORM: begin
                if (r_lost || (r_w == '0) || r_w[MAX_STEPS-1]) begin
                    n_state = S_OUT;
                end else begin
                    n_w = {r_w[MAX_STEPS-2:0], 1'b0};
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_opat   = r_lost ? '0 : PAT_W'(r_w);
                    n_oinv   = r_inv;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sp     <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_sp     <= n_sp;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_r    <= n_r;
        r_lvl  <= n_lvl;
        r_inv  <= n_inv;
        r_f    <= n_f;
        r_w    <= n_w;
        r_lost <= n_lost;
        r_len  <= n_len;
        r_opat <= n_opat;
        r_oinv <= n_oinv;
    end

    // level tables and frame stack
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_a[cnt_wa] <= cnt_wd;
        end
        if (rem_we) begin
            r_rem_a[rem_wa] <= rem_wd;
        end
        if (stk_we) begin
            r_stk[r_sp[LVL_W-1:0]] <= stk_wd;
        end
    end

endmodule

// ----- design/euclidean_rhythm_generator.sv -----
// Path: rejected and zero-hit requests pass from the back end's idle state straight to
//   its output state; others run the division chain, expand the level tree and make up to
//   MAX_STEPS-1 alignment shifts before they reach the output state.
// Throughput: one request at a time in the back end; a 2-entry queue and the output
//   register let input and output stall independently.
// Reset: synchronous active-low i_rst_n empties the queue and drops o_valid.
// ----------------------------------------------------------------------------
// Euclidean rhythm generator
// Turns a hit count and a step count into a left-aligned Bjorklund pattern.
// ----------------------------------------------------------------------------
`include "euclidean_rhythm_generator_defines.svh"

module euclidean_rhythm_generator import erg_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CNT_W-1:0] i_hit_count,
    input  logic [CNT_W-1:0] i_step_count,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PAT_W-1:0] o_pattern,
    output logic             o_invalid
);

    logic   q_push;
    logic   q_pop;
    t_job   q_in;
    t_job   q_head;
    t_q_sts q_sts;

    // request intake and classification
    erg_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hit_count  (i_hit_count),
        .i_step_count (i_step_count),
        .i_q_sts      (q_sts),
        .o_push       (q_push),
        .o_job        (q_in)
    );

    erg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_sts   (q_sts)
    );

    // computation and result register
    erg_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_sts   (q_sts),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_pattern (o_pattern),
        .o_invalid (o_invalid)
    );

    // checks
    `ERG_ASSERT_IMP(a_inv_zero, o_valid && o_invalid, o_pattern == '0, "invalid result with nonzero pattern")
    `ERG_ASSERT_IMP(a_empty_rdy, q_sts.empty, o_ready, "empty queue but request refused")
    `ERG_ASSERT_NXT(a_empty_hold, q_sts.empty && !(i_valid && o_ready), q_sts.empty, "queue filled without a request")

endmodule

// ----- tb/sv/erg_rhythm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean rhythm checker
// Watches the request and result channels of the rhythm generator. Every
// accepted request gets its pattern worked out here and queued. Each result
// is then compared field by field against the oldest queued pattern.
// ----------------------------------------------------------------------------
module erg_rhythm_checker import erg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  logic [CNT_W-1:0] i_hit_count,
    input  logic [CNT_W-1:0] i_step_count,
    input  logic             i_rsp_valid,
    input  logic             i_rsp_ready,
    input  logic [PAT_W-1:0] i_pattern,
    input  logic             i_invalid,
    output int               o_err_cnt,
    output int               o_pending,
    output int               o_checked,
    output int               o_rejected
);

    localparam int STEP_MAX  = MAX_STEPS_DEF;
    localparam int LVL_SLOTS = STEP_MAX + 4;
    localparam int STK_DEPTH = 32;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic             invalid;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] steps;
    } t_rhythm;

    t_rhythm rhythm_q[$];
    int      err_cnt  = 0;
    int      checked  = 0;
    int      rejected = 0;

    // Bjorklund spread of hits over steps, left aligned to bit STEP_MAX-1.
    // The nested expansion runs on an explicit stack instead of recursion.
    function automatic logic [63:0] spread_hits(input int unsigned hits,
                                                input int unsigned steps);
        int unsigned lvl_cnt[LVL_SLOTS];
        int unsigned lvl_rem[LVL_SLOTS];
        int unsigned divisor;
        int unsigned r;
        int unsigned len;
        int          level;
        int          top;
        int          sp;
        int          lv;
        int          stk_lvl[STK_DEPTH];
        int unsigned stk_idx[STK_DEPTH];
        bit          stk_tail[STK_DEPTH];
        logic [63:0] bits;

        for (int i = 0; i < LVL_SLOTS; i++) begin
            lvl_cnt[i] = 0;
            lvl_rem[i] = 0;
        end
        bits    = '0;
        len     = 0;
        top     = -1;
        level   = 0;
        divisor = steps - hits;

        // division chain: per-level counts and remainders
        lvl_rem[0] = hits;
        while (1) begin
            r = lvl_rem[level];
            if (r == 0 || level + 1 >= LVL_SLOTS)
                break;
            lvl_cnt[level]     = divisor / r;
            lvl_rem[level + 1] = divisor % r;
            divisor            = r;
            level++;
            if (lvl_rem[level] <= 1)
                break;
        end
        lvl_cnt[level] = divisor;

        // nested expansion; level -1 is a rest, -2 a hit
        stk_lvl[0]  = level;
        stk_idx[0]  = 0;
        stk_tail[0] = 1'b0;
        sp          = 1;
        while (sp > 0) begin
            lv = stk_lvl[sp-1];
            if (lv == -1 || lv == -2) begin
                if (len < 63) begin
                    bits = {bits[62:0], (lv == -2)};
                    len++;
                end
                sp--;
            end else if (lv < 0 || lv >= LVL_SLOTS) begin
                sp--;
            end else if (stk_idx[sp-1] < lvl_cnt[lv]) begin
                stk_idx[sp-1]++;
                stk_lvl[sp]  = lv - 1;
                stk_idx[sp]  = 0;
                stk_tail[sp] = 1'b0;
                sp++;
            end else if (!stk_tail[sp-1] && lvl_rem[lv] != 0) begin
                stk_tail[sp-1] = 1'b1;
                stk_lvl[sp]    = lv - 2;
                stk_idx[sp]    = 0;
                stk_tail[sp]   = 1'b0;
                sp++;
            end else begin
                sp--;
            end
        end

        // left align the top set bit
        for (int i = 0; i < 63; i++)
            if (bits[i])
                top = i;
        if (top < 0 || top > STEP_MAX - 1)
            return '0;
        return bits << (STEP_MAX - 1 - top);
    endfunction

    function automatic t_rhythm predict_rhythm(input logic [CNT_W-1:0] hits,
                                               input logic [CNT_W-1:0] steps);
        t_rhythm     res;
        logic [63:0] wide;

        res.hits    = hits;
        res.steps   = steps;
        res.pattern = '0;
        res.invalid = 1'b0;
        if (steps == 0 || hits > steps || steps > STEP_MAX) begin
            res.invalid = 1'b1;
        end else if (hits != 0) begin
            wide        = spread_hits(32'(hits), 32'(steps));
            res.pattern = wide[PAT_W-1:0];
        end
        return res;
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_rhythm want;

        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                want = predict_rhythm(i_hit_count, i_step_count);
                rhythm_q.push_back(want);
                if (want.invalid)
                    rejected++;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (rhythm_q.size() == 0) begin
                    $display("%0t: result with no request waiting: pattern %h invalid %b",
                             $time, i_pattern, i_invalid);
                    err_cnt++;
                end else begin
                    want = rhythm_q.pop_front();
                    checked++;
                    if (i_pattern !== want.pattern) begin
                        $display("%0t: pattern mismatch (hits %0d steps %0d): exp %h got %h",
                                 $time, want.hits, want.steps, want.pattern, i_pattern);
                        err_cnt++;
                    end
                    if (i_invalid !== want.invalid) begin
                        $display("%0t: invalid mismatch (hits %0d steps %0d): exp %b got %b",
                                 $time, want.hits, want.steps, want.invalid, i_invalid);
                        err_cnt++;
                    end
                end
            end
        end
        o_err_cnt  <= err_cnt;
        o_pending  <= rhythm_q.size();
        o_checked  <= checked;
        o_rejected <= rejected;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean rhythm generator testbench
// Drives corner-case and random hit/step requests with random idling on both
// channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import erg_pkg::*; ();

    localparam int  RAND_ITEMS  = 1300;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  TAIL_CYCLES = 150;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             req_valid  = 1'b0;
    logic             req_ready;
    logic [CNT_W-1:0] hit_count  = '0;
    logic [CNT_W-1:0] step_count = '0;
    logic             rsp_valid;
    logic             rsp_ready  = 1'b0;
    logic [PAT_W-1:0] pattern;
    logic             invalid;

    int err_cnt;
    int pending;
    int checked;
    int rejected;
    int sent   = 0;
    int cycles = 0;
    bit calm   = 1'b0;   // no idling on either side while set

    euclidean_rhythm_generator dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_ready      (req_ready),
        .i_hit_count  (hit_count),
        .i_step_count (step_count),
        .o_valid      (rsp_valid),
        .i_ready      (rsp_ready),
        .o_pattern    (pattern),
        .o_invalid    (invalid)
    );

    erg_rhythm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_hit_count  (hit_count),
        .i_step_count (step_count),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_pattern    (pattern),
        .i_invalid    (invalid),
        .o_err_cnt    (err_cnt),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_rejected   (rejected)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** euclidean_rhythm_generator: FAILED **");
            $finish;
        end
    end

    // result side stalls at random, never while calm is set
    always @(negedge clk) begin
        rsp_ready <= calm || ($urandom_range(99) >= 7);
    end

    // one request: random gaps first, then hold until accepted
    task automatic send_request(input logic [CNT_W-1:0] hits,
                                input logic [CNT_W-1:0] steps);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 7) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid  <= 1'b1;
        hit_count  <= hits;
        step_count <= steps;
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
    endtask

    // stop sending until every result is back
    task automatic drain_results;
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] h;
        logic [CNT_W-1:0] s;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners: empty, full, single hit, common rhythms, rejects
        send_request(5'd0,  5'd0);
        send_request(5'd0,  5'd1);
        send_request(5'd1,  5'd1);
        send_request(5'd0,  5'd16);
        send_request(5'd1,  5'd16);
        send_request(5'd15, 5'd16);
        send_request(5'd16, 5'd16);
        send_request(5'd3,  5'd8);
        send_request(5'd5,  5'd8);
        send_request(5'd4,  5'd12);
        send_request(5'd5,  5'd13);
        send_request(5'd7,  5'd16);
        send_request(5'd9,  5'd16);
        send_request(5'd11, 5'd16);
        send_request(5'd13, 5'd16);
        send_request(5'd2,  5'd3);
        send_request(5'd3,  5'd7);
        send_request(5'd2,  5'd1);
        send_request(5'd17, 5'd16);
        send_request(5'd0,  5'd17);
        send_request(5'd1,  5'd17);
        send_request(5'd16, 5'd31);
        send_request(5'd31, 5'd31);
        send_request(5'd5,  5'd0);
        drain_results();

        // random mix: mostly legal counts, some anywhere in the field range
        for (int i = 0; i < RAND_ITEMS; i++) begin
            calm = (i >= 400 && i < 650);
            if ($urandom_range(99) < 85) begin
                s = CNT_W'($urandom_range(16, 1));
                h = CNT_W'($urandom_range(s, 0));
            end else begin
                h = CNT_W'($urandom_range(31, 0));
                s = CNT_W'($urandom_range(31, 0));
            end
            send_request(h, s);
            if (i % 330 == 329)
                drain_results();
        end
        calm = 1'b0;

        // wrap up
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d rejected by range), %0d results compared.",
                 sent, rejected, checked);
        $display("Corners plus random counts, with stalls on both sides and drain pauses.");
        if (err_cnt == 0)
            $display("** euclidean_rhythm_generator: PASSED **");
        else
            $display("** euclidean_rhythm_generator: FAILED **");
        $finish;
    end

endmodule
